// File: design/spq_pkg.sv
// Package of shared types and constants for the sorted priority queue.
package spq_pkg;

   localparam int DEF_CAPACITY = 16;
   localparam int WORD_W       = 32;
   localparam int ENTRY_W      = 2 * WORD_W;

   typedef enum logic [1:0] {
      CMD_PUSH  = 2'd0,
      CMD_POP   = 2'd1,
      CMD_CLEAR = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      RD_HEAD = 2'd0,
      RD_CUR  = 2'd1,
      RD_NEXT = 2'd2
   } rd_sel_type;

   typedef enum logic [2:0] {
      S_IDLE      = 3'd0,
      S_POP_DATA  = 3'd1,
      S_PUSH_RD   = 3'd2,
      S_PUSH_CMP  = 3'd3,
      S_PUSH_LAST = 3'd4,
      S_FINISH    = 3'd5
   } state_type;

   typedef struct packed {
      logic       accept;
      status_type status_code;
      logic       rd_en;
      rd_sel_type rd_sel;
      logic       wr_shift;
      logic       wr_new;
      logic       pop_take;
      logic       clear;
      logic       load_rsp;
   } dp_cmd_type;

   typedef struct packed {
      logic count_zero;
      logic count_full;
      logic k_zero;
      logic k_one;
      logic greater;
      logic rsp_free;
   } dp_status_type;

endpackage

// File: design/sorted_priority_queue.sv
// Top level of the sorted priority queue: controller, datapath and store.
//
//   Channel  Ports                                           Direction
//   req      req_valid, req_stall, req_cmd, req_value,       in (stall out)
//            req_priority_req
//   rsp      rsp_valid, rsp_stall, rsp_status, rsp_out_value, out (stall in)
//            rsp_out_priority, rsp_is_empty, rsp_is_full
//
// Entries sit in order in a circular RAM; a pop reads the head slot, a push walks
// from the tail towards the head, moving one larger entry per cycle through the RAM.
// Clear, a push into a full queue and a pop on an empty one go straight to finishing;
// a pop first reads the head slot, and a push first shifts each larger stored entry.
// One item is in work at a time; the next is taken while the previous result waits.
// Reset is synchronous and empties the queue; RAM contents are left as they are.
module sorted_priority_queue import spq_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_cmd,
   input  logic signed [WORD_W-1:0] req_value,
   input  logic signed [WORD_W-1:0] req_priority_req,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [1:0]               rsp_status,
   output logic signed [WORD_W-1:0] rsp_out_value,
   output logic signed [WORD_W-1:0] rsp_out_priority,
   output logic                     rsp_is_empty,
   output logic                     rsp_is_full
);

   dp_cmd_type    dp_cmd;
   dp_status_type dp_sts;

   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_cmd   (req_cmd),
      .req_stall (req_stall),
      .sts       (dp_sts),
      .cmd       (dp_cmd)
   );

   spq_dp #(
      .CAPACITY (CAPACITY)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_value        (req_value),
      .req_priority_req (req_priority_req),
      .cmd              (dp_cmd),
      .sts              (dp_sts),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_out_value    (rsp_out_value),
      .rsp_out_priority (rsp_out_priority),
      .rsp_is_empty     (rsp_is_empty),
      .rsp_is_full      (rsp_is_full)
   );

endmodule

// File: design/spq_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module spq_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/spq_ctrl.sv
// Controller state machine that sequences push, pop and clear operations.
module spq_ctrl import spq_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic [1:0]    req_cmd,
   output logic          req_stall,
   input  dp_status_type sts,
   output dp_cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      cmd             = '0;
      cmd.status_code = ST_OK;
      cmd.rd_sel      = RD_HEAD;
      req_stall       = (state_ff != S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               unique case (req_cmd)
                  CMD_PUSH: begin
                     if (sts.count_full) begin
                        cmd.status_code = ST_FULL;
                        state_in        = S_FINISH;
                     end else begin
                        state_in = S_PUSH_RD;
                     end
                  end
                  CMD_POP: begin
                     if (sts.count_zero) begin
                        cmd.status_code = ST_EMPTY;
                        state_in        = S_FINISH;
                     end else begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = RD_HEAD;
                        state_in   = S_POP_DATA;
                     end
                  end
                  CMD_CLEAR: begin
                     cmd.clear = 1'b1;
                     state_in  = S_FINISH;
                  end
                  default: begin
                     state_in = S_FINISH;
                  end
               endcase
            end
         end
         S_POP_DATA: begin
            cmd.pop_take = 1'b1;
            state_in     = S_FINISH;
         end
         S_PUSH_RD: begin
            if (sts.k_zero) begin
               cmd.wr_new = 1'b1;
               state_in   = S_FINISH;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_CUR;
               state_in   = S_PUSH_CMP;
            end
         end
         S_PUSH_CMP: begin
            // A larger stored priority moves one slot towards the tail.
            if (sts.greater) begin
               cmd.wr_shift = 1'b1;
               if (sts.k_one) begin
                  state_in = S_PUSH_LAST;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RD_NEXT;
               end
            end else begin
               cmd.wr_new = 1'b1;
               state_in   = S_FINISH;
            end
         end
         S_PUSH_LAST: begin
            cmd.wr_new = 1'b1;
            state_in   = S_FINISH;
         end
         S_FINISH: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: design/spq_dp.sv
// Datapath: circular sorted store, insertion pointers and the result register.
module spq_dp import spq_pkg::*; #(
   parameter int CAPACITY = DEF_CAPACITY
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [WORD_W-1:0] req_value,
   input  logic signed [WORD_W-1:0] req_priority_req,
   input  dp_cmd_type               cmd,
   output dp_status_type            sts,
   input  logic                     rsp_stall,
   output logic                     rsp_valid,
   output logic [1:0]               rsp_status,
   output logic signed [WORD_W-1:0] rsp_out_value,
   output logic signed [WORD_W-1:0] rsp_out_priority,
   output logic                     rsp_is_empty,
   output logic                     rsp_is_full
);

   localparam int PTR_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(CAPACITY - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
      return (p == '0) ? PTR_W'(CAPACITY - 1) : p - 1'b1;
   endfunction

   logic [PTR_W-1:0]  head_ff, head_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [WORD_W-1:0] new_value_ff, new_value_in;
   logic [WORD_W-1:0] new_prio_ff, new_prio_in;
   status_type        res_status_ff, res_status_in;
   logic [WORD_W-1:0] res_value_ff, res_value_in;
   logic [WORD_W-1:0] res_prio_ff, res_prio_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_status_ff, rsp_status_in;
   logic [WORD_W-1:0] rsp_value_ff, rsp_value_in;
   logic [WORD_W-1:0] rsp_prio_ff, rsp_prio_in;
   logic              rsp_empty_ff, rsp_empty_in;
   logic              rsp_full_ff, rsp_full_in;

   logic [PTR_W:0]     tail_sum;
   logic [PTR_W:0]     tail_wrap;
   logic [PTR_W-1:0]   tail_ptr;
   logic               ram_wr_en;
   logic [PTR_W-1:0]   ram_rd_addr;
   logic [ENTRY_W-1:0] ram_wr_data;
   logic [ENTRY_W-1:0] ram_rd_data;
   logic [WORD_W-1:0]  rd_value;
   logic [WORD_W-1:0]  rd_prio;

   // Physical slot just behind the last stored entry.
   assign tail_sum  = {1'b0, head_ff} + (PTR_W + 1)'(count_ff);
   assign tail_wrap = tail_sum - (PTR_W + 1)'(CAPACITY);
   assign tail_ptr  = (tail_sum >= (PTR_W + 1)'(CAPACITY)) ?
                      tail_wrap[PTR_W-1:0] : tail_sum[PTR_W-1:0];

   assign rd_prio  = ram_rd_data[ENTRY_W-1:WORD_W];
   assign rd_value = ram_rd_data[WORD_W-1:0];

   always_comb begin
      unique case (cmd.rd_sel)
         RD_HEAD: ram_rd_addr = head_ff;
         RD_CUR:  ram_rd_addr = rd_ptr_ff;
         RD_NEXT: ram_rd_addr = ptr_dec(rd_ptr_ff);
         default: ram_rd_addr = head_ff;
      endcase
   end

   assign ram_wr_en   = cmd.wr_shift | cmd.wr_new;
   assign ram_wr_data = cmd.wr_shift ? ram_rd_data : {new_prio_ff, new_value_ff};

   spq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (wr_ptr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (cmd.rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign sts.count_zero = (count_ff == '0);
   assign sts.count_full = (count_ff == CNT_W'(CAPACITY));
   assign sts.k_zero     = (k_ff == '0);
   assign sts.k_one      = (k_ff == CNT_W'(1));
   assign sts.greater    = ($signed(rd_prio) > $signed(new_prio_ff));
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      wr_ptr_in     = wr_ptr_ff;
      rd_ptr_in     = rd_ptr_ff;
      k_in          = k_ff;
      new_value_in  = new_value_ff;
      new_prio_in   = new_prio_ff;
      res_status_in = res_status_ff;
      res_value_in  = res_value_ff;
      res_prio_in   = res_prio_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_prio_in   = rsp_prio_ff;
      rsp_empty_in  = rsp_empty_ff;
      rsp_full_in   = rsp_full_ff;

      if (cmd.accept) begin
         new_value_in  = req_value;
         new_prio_in   = req_priority_req;
         res_status_in = cmd.status_code;
         res_value_in  = '0;
         res_prio_in   = '0;
         k_in          = count_ff;
         wr_ptr_in     = tail_ptr;
         rd_ptr_in     = ptr_dec(tail_ptr);
      end
      if (cmd.wr_shift) begin
         wr_ptr_in = rd_ptr_ff;
         rd_ptr_in = ptr_dec(rd_ptr_ff);
         k_in      = k_ff - 1'b1;
      end
      if (cmd.wr_new) begin
         count_in = count_ff + 1'b1;
      end
      if (cmd.pop_take) begin
         res_value_in = rd_value;
         res_prio_in  = rd_prio;
         head_in      = ptr_inc(head_ff);
         count_in     = count_ff - 1'b1;
      end
      if (cmd.clear) begin
         count_in = '0;
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.load_rsp) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status_ff;
         rsp_value_in  = res_value_ff;
         rsp_prio_in   = res_prio_ff;
         rsp_empty_in  = (count_ff == '0);
         rsp_full_in   = (count_ff == CNT_W'(CAPACITY));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wr_ptr_ff     <= wr_ptr_in;
      rd_ptr_ff     <= rd_ptr_in;
      k_ff          <= k_in;
      new_value_ff  <= new_value_in;
      new_prio_ff   <= new_prio_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_prio_ff   <= res_prio_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_prio_ff   <= rsp_prio_in;
      rsp_empty_ff  <= rsp_empty_in;
      rsp_full_ff   <= rsp_full_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_out_value    = rsp_value_ff;
   assign rsp_out_priority = rsp_prio_ff;
   assign rsp_is_empty     = rsp_empty_ff;
   assign rsp_is_full      = rsp_full_ff;

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench of the sorted priority queue, with its own ordered-list predictor.
module tb_top import spq_pkg::*;;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int QUEUE_DEPTH = DEF_CAPACITY;
   localparam int STUCK_LIMIT = 4000;
   localparam int ITEMS_PER_PHASE = 260;
   localparam logic [1:0] CMD_NOP = 2'd3;
   localparam logic signed [WORD_W-1:0] PRIO_MIN = 32'sh8000_0000;
   localparam logic signed [WORD_W-1:0] PRIO_MAX = 32'sh7fff_ffff;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } op_mix_type;

   typedef struct {
      logic [1:0]               cmd;
      logic signed [WORD_W-1:0] value;
      logic signed [WORD_W-1:0] prio;
   } queue_request_type;

   typedef struct {
      status_type               status;
      logic signed [WORD_W-1:0] value;
      logic signed [WORD_W-1:0] prio;
      logic                     empty;
      logic                     full;
   } queue_reply_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [1:0]               req_cmd = CMD_NOP;
   logic signed [WORD_W-1:0] req_value = '0;
   logic signed [WORD_W-1:0] req_priority_req = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [1:0]               rsp_status;
   logic signed [WORD_W-1:0] rsp_out_value;
   logic signed [WORD_W-1:0] rsp_out_priority;
   logic                     rsp_is_empty;
   logic                     rsp_is_full;

   queue_request_type queued_requests[$];
   queue_reply_type   predicted_replies[$];

   // Shadow copy of the ordered store; slot 0 leaves first.
   logic signed [WORD_W-1:0] shadow_values[QUEUE_DEPTH];
   logic signed [WORD_W-1:0] shadow_prios[QUEUE_DEPTH];
   int                       shadow_count = 0;

   int   send_idle_pct = 0;
   int   stall_pct = 0;
   int   mismatches = 0;
   int   stuck_cycles = 0;
   logic req_taken = 1'b0;

   sorted_priority_queue #(
      .CAPACITY(QUEUE_DEPTH)
   ) u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_cmd         (req_cmd),
      .req_value       (req_value),
      .req_priority_req(req_priority_req),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_out_value   (rsp_out_value),
      .rsp_out_priority(rsp_out_priority),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_is_full     (rsp_is_full)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic queue_reply_type apply_queue_op(queue_request_type r);
      queue_reply_type rep;
      int pos;
      rep.status = ST_OK;
      rep.value  = '0;
      rep.prio   = '0;
      case (r.cmd)
         CMD_PUSH: begin
            if (shadow_count >= QUEUE_DEPTH) begin
               rep.status = ST_FULL;
            end else begin
               // The new entry goes behind every entry of equal or smaller priority.
               pos = 0;
               while (pos < shadow_count && !(shadow_prios[pos] > r.prio)) pos++;
               for (int k = shadow_count; k > pos; k--) begin
                  shadow_values[k] = shadow_values[k-1];
                  shadow_prios[k]  = shadow_prios[k-1];
               end
               shadow_values[pos] = r.value;
               shadow_prios[pos]  = r.prio;
               shadow_count++;
            end
         end
         CMD_POP: begin
            if (shadow_count == 0) begin
               rep.status = ST_EMPTY;
            end else begin
               rep.value = shadow_values[0];
               rep.prio  = shadow_prios[0];
               for (int k = 1; k < shadow_count; k++) begin
                  shadow_values[k-1] = shadow_values[k];
                  shadow_prios[k-1]  = shadow_prios[k];
               end
               shadow_count--;
            end
         end
         CMD_CLEAR: begin
            shadow_count = 0;
         end
         default: begin
         end
      endcase
      rep.empty = (shadow_count == 0);
      rep.full  = (shadow_count >= QUEUE_DEPTH);
      return rep;
   endfunction

   task automatic check_field(input string field, input logic [WORD_W-1:0] want,
                              input logic [WORD_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %h, actual %h", field, want, got);
         mismatches++;
      end
   endtask

   task automatic add_request(input logic [1:0] cmd, input logic signed [WORD_W-1:0] value,
                              input logic signed [WORD_W-1:0] prio);
      queue_request_type r;
      r.cmd   = cmd;
      r.value = value;
      r.prio  = prio;
      queued_requests.push_back(r);
   endtask

   // Random request; priorities cluster in a narrow band so that ties are common.
   task automatic add_random_request(input op_mix_type mix);
      int push_pct;
      int roll;
      int pick;
      logic [1:0] cmd;
      logic signed [WORD_W-1:0] prio;
      case (mix)
         MIX_FILL:  push_pct = 70;
         MIX_DRAIN: push_pct = 25;
         default:   push_pct = 50;
      endcase
      roll = $urandom_range(99);
      if (roll < push_pct) cmd = CMD_PUSH;
      else if (roll < 96) cmd = CMD_POP;
      else if (roll < 98) cmd = CMD_CLEAR;
      else cmd = CMD_NOP;
      pick = $urandom_range(9);
      if (pick < 5) prio = $signed($urandom_range(6)) - 3;
      else if (pick < 8) prio = $urandom;
      else if (pick == 8) prio = $urandom_range(1) ? PRIO_MAX : PRIO_MIN;
      else prio = $signed($urandom_range(16)) - 8;
      add_request(cmd, $urandom, prio);
   endtask

   // Driver: payload changes only at the falling edge and only once the item is taken.
   always @(negedge clock) begin
      queue_request_type r;
      if (!reset) begin
         if (!req_valid || req_taken) begin
            if (queued_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               r = queued_requests.pop_front();
               req_valid        <= 1'b1;
               req_cmd          <= r.cmd;
               req_value        <= r.value;
               req_priority_req <= r.prio;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // Monitor: predicts on each accepted request and checks each accepted result.
   always @(posedge clock) begin
      queue_request_type seen;
      queue_reply_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            seen.cmd   = req_cmd;
            seen.value = req_value;
            seen.prio  = req_priority_req;
            predicted_replies.push_back(apply_queue_op(seen));
         end
         if (rsp_valid && !rsp_stall) begin
            if (predicted_replies.size() == 0) begin
               $error("result item with no expectation waiting");
               mismatches++;
            end else begin
               want = predicted_replies.pop_front();
               check_field("status", want.status, rsp_status);
               check_field("out_value", want.value, rsp_out_value);
               check_field("out_priority", want.prio, rsp_out_priority);
               check_field("is_empty", want.empty, rsp_is_empty);
               check_field("is_full", want.full, rsp_is_full);
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck_cycles <= 0;
         else stuck_cycles <= stuck_cycles + 1;
      end
      req_taken <= !reset && req_valid && !req_stall;
   end

   initial begin : watchdog
      wait (stuck_cycles >= STUCK_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : stimulus
      int burst_left;
      op_mix_type mix;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed opening: empty-queue cases, extreme words, ties, overflow and clear.
      add_request(CMD_POP, 32'sh1234_5678, 32'sh0);
      add_request(CMD_NOP, 32'shffff_ffff, PRIO_MAX);
      add_request(CMD_CLEAR, 32'sh0, 32'sh0);
      add_request(CMD_PUSH, PRIO_MAX, PRIO_MAX);
      add_request(CMD_PUSH, PRIO_MIN, PRIO_MIN);
      add_request(CMD_PUSH, -32'sd1, 32'sh0);
      add_request(CMD_PUSH, 32'sh0, 32'sh0);
      add_request(CMD_PUSH, 32'sh1, -32'sd1);
      for (int k = 0; k < 11; k++) add_request(CMD_PUSH, 100 + k, (k % 3) - 1);
      add_request(CMD_PUSH, 32'sh5a5a_a5a5, PRIO_MIN);
      add_request(CMD_NOP, 32'sh0, 32'sh0);
      add_request(CMD_POP, 32'sh0, 32'sh0);
      add_request(CMD_PUSH, 32'sha5a5_5a5a, PRIO_MAX);
      add_request(CMD_CLEAR, 32'sh0, 32'sh0);
      add_request(CMD_POP, 32'sh0, 32'sh0);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 80; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 80; end
            default: begin send_idle_pct = 31; stall_pct = 31; end
         endcase
         burst_left = 0;
         mix = MIX_EVEN;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            // Bursts that lean towards filling or draining take the queue to both ends.
            if (burst_left == 0) begin
               burst_left = $urandom_range(32, 12);
               mix = op_mix_type'($urandom_range(2));
            end
            add_random_request(mix);
            burst_left--;
         end
         while (queued_requests.size() != 0 || req_valid) @(posedge clock);
      end

      send_idle_pct = 0;
      stall_pct = 0;
      while (predicted_replies.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatches == 0 && predicted_replies.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// File: filelist.f
design/spq_pkg.sv
design/spq_ram.sv
design/spq_ctrl.sv
design/spq_dp.sv
design/sorted_priority_queue.sv
tb/sv/tb_top.sv
